// ===== design/gwm_pkg.sv =====
// Shared types and constants for the glob wildcard matcher.
`timescale 1ns / 1ps
`default_nettype none

package gwm_pkg;

    localparam int PATTERN_MAX = 32;

    localparam logic [7:0] STAR_CODE     = 8'd42;
    localparam logic [7:0] QUESTION_CODE = 8'd63;

    typedef enum logic [1:0] {
        FUNC_CLEAR  = 2'd0,
        FUNC_APPEND = 2'd1,
        FUNC_TEXT   = 2'd2,
        FUNC_END    = 2'd3
    } t_func;

    typedef struct packed {
        t_func      func;
        logic [7:0] char_code;
    } t_in_word;

    typedef struct packed {
        logic matched;
        logic pattern_overflow;
    } t_out_word;

    typedef logic [PATTERN_MAX-1:0] t_pat_vec;
    typedef logic [PATTERN_MAX:0]   t_pos_vec;

    // per-position view of the stored pattern for the automaton
    typedef struct packed {
        t_pat_vec star;     // live position holding '*'
        t_pat_vec hit;      // live non-star position that consumes the current byte
        t_pos_vec last;     // one-hot at index pattern_length
        logic     overflow;
    } t_pat_view;

endpackage

`default_nettype wire

// ===== design/gwm_pattern_store.sv =====
// Pattern byte store, length mask, overflow flag and per-position byte compare.
`timescale 1ns / 1ps
`default_nettype none

module gwm_pattern_store (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_clear,
    input  wire logic               i_append,
    input  wire logic [7:0]         i_char,
    output gwm_pkg::t_pat_view      o_view
);

    logic [7:0]        r_pat [gwm_pkg::PATTERN_MAX];
    gwm_pkg::t_pat_vec r_live;
    gwm_pkg::t_pat_vec n_live;
    logic              r_ovf;
    logic              n_ovf;
    logic              full;
    gwm_pkg::t_pos_vec last;

    assign full = r_live[gwm_pkg::PATTERN_MAX-1];
    assign last = {r_live, 1'b1} & ~{1'b0, r_live};

    always_comb begin
        n_live = r_live;
        n_ovf  = r_ovf;
        if (i_clear) begin
            n_live = '0;
            n_ovf  = 1'b0;
        end else if (i_append) begin
            if (full) begin
                n_ovf = 1'b1;
            end else begin
                n_live = {r_live[gwm_pkg::PATTERN_MAX-2:0], 1'b1};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live <= '0;
            r_ovf  <= 1'b0;
        end else begin
            r_live <= n_live;
            r_ovf  <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < gwm_pkg::PATTERN_MAX; i++) begin
            if (i_append && !i_clear && !full && last[i]) begin
                r_pat[i] <= i_char;
            end
        end
    end

    always_comb begin
        o_view.star     = '0;
        o_view.hit      = '0;
        o_view.last     = last;
        o_view.overflow = r_ovf;
        for (int i = 0; i < gwm_pkg::PATTERN_MAX; i++) begin
            o_view.star[i] = r_live[i] && (r_pat[i] == gwm_pkg::STAR_CODE);
            o_view.hit[i]  = r_live[i] && (r_pat[i] != gwm_pkg::STAR_CODE)
                             && ((r_pat[i] == gwm_pkg::QUESTION_CODE) || (r_pat[i] == i_char));
        end
    end

endmodule

`default_nettype wire

// ===== design/gwm_nfa.sv =====
// Active-position bit vector with star closure and one-byte step.
`timescale 1ns / 1ps
`default_nettype none

module gwm_nfa (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_step,
    input  wire logic               i_restart,
    input  wire gwm_pkg::t_pat_view i_view,
    output logic                    o_matched
);

    localparam gwm_pkg::t_pos_vec START = gwm_pkg::t_pos_vec'(1);

    gwm_pkg::t_pos_vec r_active;
    gwm_pkg::t_pos_vec n_active;
    gwm_pkg::t_pat_vec seed;
    gwm_pkg::t_pos_vec sum;
    gwm_pkg::t_pos_vec carry;
    gwm_pkg::t_pos_vec closed;
    gwm_pkg::t_pos_vec stepped;

    // star runs propagate like a carry chain: carry into i+1 = seed[i] | star[i] & carry[i]
    assign seed    = r_active[gwm_pkg::PATTERN_MAX-1:0] & i_view.star;
    assign sum     = {1'b0, seed} + {1'b0, i_view.star};
    assign carry   = sum ^ {1'b0, seed} ^ {1'b0, i_view.star};
    assign closed  = r_active | carry;
    assign stepped = {1'b0, closed[gwm_pkg::PATTERN_MAX-1:0] & i_view.star}
                   | {closed[gwm_pkg::PATTERN_MAX-1:0] & i_view.hit, 1'b0};

    assign o_matched = |(closed & i_view.last);

    always_comb begin
        n_active = r_active;
        if (i_restart) begin
            n_active = START;
        end else if (i_step) begin
            n_active = stepped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= START;
        end else begin
            r_active <= n_active;
        end
    end

endmodule

`default_nettype wire

// ===== design/glob_wildcard_matcher.sv =====
// Top level of the glob wildcard matcher: input register, pattern store, automaton, result register.
//
//  port group   direction  handshake                  word
//  in           slave      i_in_valid / o_in_ready    gwm_pkg::t_in_word  (func, char_code)
//  out          master     o_out_valid / i_out_ready  gwm_pkg::t_out_word (matched, overflow)
//
// One word per cycle unless an end word stalls; results pass the input and result registers.
// The single path is the 33-bit star-closure carry chain plus 32 byte compares.
// Reset clears the pattern, the overflow flag and restarts the automaton; no sweep.
// Only an end-of-text word waits on a full result register; other words never stall.
`timescale 1ns / 1ps
`default_nettype none

module glob_wildcard_matcher (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire gwm_pkg::t_in_word  i_in_word,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output gwm_pkg::t_out_word      o_out_word
);

    logic               r_in_valid;
    gwm_pkg::t_in_word  r_in_word;
    logic               r_out_valid;
    gwm_pkg::t_out_word r_out_word;
    logic               out_free;
    logic               advance;
    logic               is_end;
    logic               matched;
    gwm_pkg::t_pat_view view;

    assign is_end     = (r_in_word.func == gwm_pkg::FUNC_END);
    assign out_free   = !r_out_valid || i_out_ready;
    assign advance    = r_in_valid && (!is_end || out_free);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_word <= i_in_word;
        end
    end

    gwm_pattern_store u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (advance && (r_in_word.func == gwm_pkg::FUNC_CLEAR)),
        .i_append (advance && (r_in_word.func == gwm_pkg::FUNC_APPEND)),
        .i_char   (r_in_word.char_code),
        .o_view   (view)
    );

    gwm_nfa u_nfa (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (advance && (r_in_word.func == gwm_pkg::FUNC_TEXT)),
        .i_restart (advance && ((r_in_word.func == gwm_pkg::FUNC_CLEAR) || is_end)),
        .i_view    (view),
        .o_matched (matched)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && is_end) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && is_end) begin
            r_out_word.matched          <= matched;
            r_out_word.pattern_overflow <= view.overflow;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |=> r_out_valid && $stable(r_out_word))
        else $error("result word changed while stalled");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> r_in_valid && is_end && r_out_valid && !i_out_ready)
        else $error("input stalled without a blocked end word");

    a_end_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && is_end |=> r_out_valid)
        else $error("end word produced no result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid && !(advance && is_end) |=> !r_out_valid)
        else $error("result appeared without an end word");

endmodule

`default_nettype wire
